>>> rtl/p2g_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_pkg
// Shared types and constants for the palette to 16-bit gray converter.
// ----------------------------------------------------------------------------
package p2g_pkg;

    // Command carried by an input word
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_PAL_SIZE = 2'd1;
    localparam logic [1:0] REG_BG       = 2'd2;

    // Transparency modes; the unused code behaves as opaque convert
    localparam logic [1:0] MODE_OPAQUE = 2'd0;
    localparam logic [1:0] MODE_OVER   = 2'd1;
    localparam logic [1:0] MODE_BG     = 2'd2;

    // Luma weights, scaled by 2^16 overall then shifted down by 8
    localparam logic [23:0] COEF_R = 24'd19672;
    localparam logic [23:0] COEF_G = 24'd38621;
    localparam logic [23:0] COEF_B = 24'd7500;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SIZE_W     = 9;

    // Stored palette entry: alpha top bit and RGB
    typedef struct packed {
        logic       opaque;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } p2g_entry_t;

endpackage

>>> rtl/p2g_pix_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_pix_in_if
// Input channel: palette load or pixel word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface p2g_pix_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  index;
    logic [31:0] palette_argb;
    logic [15:0] dst_gray;

    modport source (output valid, output cmd, output index, output palette_argb,
                    output dst_gray, input ready);
    modport sink   (input valid, input cmd, input index, input palette_argb,
                    input dst_gray, output ready);
endinterface

>>> rtl/p2g_pix_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_pix_out_if
// Output channel: converted gray pixel word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface p2g_pix_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] gray;
    logic        transparent;

    modport source (output valid, output gray, output transparent, input ready);
    modport sink   (input valid, input gray, input transparent, output ready);
endinterface

>>> rtl/p2g_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface p2g_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/p2g_palette_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2g_palette_ram
// Palette store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module p2g_palette_ram
    import p2g_pkg::*;
#(
    parameter int unsigned ENTRIES = 256
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(ENTRIES)-1:0]        waddr,
    input  p2g_entry_t                        wdata,
    input  logic                              re,
    input  logic [$clog2(ENTRIES)-1:0]        raddr,
    output p2g_entry_t                        rdata
);

    p2g_entry_t mem [ENTRIES];
    p2g_entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/palette_to_gray16_xpar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_to_gray16_xpar
// Palette index to 16-bit gray conversion with bitmask transparency.
// ----------------------------------------------------------------------------
// One word, load or pixel, is taken per clock unless stalled. A pixel's
// result passes the palette read, weighted products, and sum and select
// stages. The palette sits in a single-port-read, single-port-write RAM; a
// load written in one cycle is seen by a pixel accepted in the next, so no
// forwarding is needed. Each stage advances on its own, so input keeps
// flowing into empty stages while a result waits at the output. Unloaded
// entries read back undefined; no clearing pass runs after reset. The user
// writes configuration only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module palette_to_gray16_xpar
    import p2g_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    p2g_pix_in_if.sink    pix_in,
    p2g_pix_out_if.source pix_out,
    p2g_cfg_if.sink       cfg
);

    localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [SIZE_W-1:0] ENTRIES_LIM = SIZE_W'(PALETTE_ENTRIES);

    // Configuration registers
    logic [1:0]        mode_reg;
    logic [SIZE_W-1:0] pal_size_reg;
    logic [15:0]       bg_reg;

    // Pipeline registers
    logic        s1_v_reg, s1_inr_reg;
    logic [15:0] s1_dst_reg;
    logic        s2_v_reg, s2_inr_reg, s2_xpar_reg;
    logic [15:0] s2_dst_reg;
    logic [23:0] s2_pr_reg, s2_pg_reg, s2_pb_reg;
    logic        out_v_reg, out_xpar_reg;
    logic [15:0] out_gray_reg;

    logic              s1_en, s2_en, s3_en;
    logic              acc, acc_pix, acc_load;
    logic [SIZE_W-1:0] limit;
    logic              in_range;
    p2g_entry_t        wr_entry, rd_entry;
    logic [23:0]       luma_sum;
    logic [15:0]       gray_next;

    // Stage enables: a stage moves when it is empty or its successor moves
    assign s3_en = !out_v_reg || pix_out.ready;
    assign s2_en = !s2_v_reg || s3_en;
    assign s1_en = !s1_v_reg || s2_en;

    assign pix_in.ready = s1_en;
    assign acc          = pix_in.valid && pix_in.ready;
    assign acc_pix      = acc && (pix_in.cmd == CMD_PIXEL);
    assign acc_load     = acc && (pix_in.cmd == CMD_LOAD)
                          && ({1'b0, pix_in.index} < ENTRIES_LIM);

    // Effective palette size, clamped to the store
    assign limit    = (pal_size_reg > ENTRIES_LIM) ? ENTRIES_LIM : pal_size_reg;
    assign in_range = {1'b0, pix_in.index} < limit;

    assign wr_entry.opaque = pix_in.palette_argb[31];
    assign wr_entry.r      = pix_in.palette_argb[23:16];
    assign wr_entry.g      = pix_in.palette_argb[15:8];
    assign wr_entry.b      = pix_in.palette_argb[7:0];

    p2g_palette_ram #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (acc_load),
        .waddr (pix_in.index[AW-1:0]),
        .wdata (wr_entry),
        .re    (acc_pix),
        .raddr (pix_in.index[AW-1:0]),
        .rdata (rd_entry)
    );

    // Configuration writes; indexes beyond the list are dropped
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_OPAQUE;
            pal_size_reg <= SIZE_W'(256);
            bg_reg       <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_MODE:     mode_reg     <= cfg.data[1:0];
                REG_PAL_SIZE: pal_size_reg <= cfg.data[SIZE_W-1:0];
                REG_BG:       bg_reg       <= cfg.data;
                default:      ;
            endcase
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_v_reg <= acc_pix;
            end
            if (s2_en)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_en)
            begin
                out_v_reg <= s2_v_reg;
            end
        end
    end

    // Stage 1: side data alongside the palette read
    always_ff @(posedge clk)
    begin
        if (acc_pix)
        begin
            s1_inr_reg <= in_range;
            s1_dst_reg <= pix_in.dst_gray;
        end
    end

    // Stage 2: weighted colour products
    always_ff @(posedge clk)
    begin
        if (s2_en && s1_v_reg)
        begin
            s2_inr_reg  <= s1_inr_reg;
            s2_xpar_reg <= !rd_entry.opaque;
            s2_dst_reg  <= s1_dst_reg;
            s2_pr_reg   <= 24'(rd_entry.r) * COEF_R;
            s2_pg_reg   <= 24'(rd_entry.g) * COEF_G;
            s2_pb_reg   <= 24'(rd_entry.b) * COEF_B;
        end
    end

    // Stage 3: sum, scale and transparency select
    assign luma_sum = s2_pr_reg + s2_pg_reg + s2_pb_reg;

    always_comb
    begin
        gray_next = luma_sum[23:8];
        if (s2_xpar_reg)
        begin
            case (mode_reg)
                MODE_OVER: gray_next = s2_dst_reg;
                MODE_BG:   gray_next = bg_reg;
                default:   gray_next = luma_sum[23:8];
            endcase
        end
        if (!s2_inr_reg)
        begin
            gray_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en && s2_v_reg)
        begin
            out_gray_reg <= gray_next;
            out_xpar_reg <= s2_inr_reg && s2_xpar_reg;
        end
    end

    assign pix_out.valid       = out_v_reg;
    assign pix_out.gray        = out_gray_reg;
    assign pix_out.transparent = out_xpar_reg;

`ifndef SYNTH
    // A palette load never produces a result word
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && pix_in.cmd == CMD_LOAD) |=> !s1_v_reg)
        else $error("load word entered the result pipeline");

    // Input must back off when every stage is full and the output stalls
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_v_reg && s2_v_reg && out_v_reg && !pix_out.ready) |-> !pix_in.ready)
        else $error("input accepted into a full pipeline");

    // Transparent result in background mode carries the background pixel
    a_bg_select: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && pix_out.transparent && mode_reg == MODE_BG)
        |-> (pix_out.gray == bg_reg))
        else $error("background pixel not substituted");

    // A pixel moving on from stage two fills the result slot
    a_s2_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_v_reg && s3_en) |=> out_v_reg)
        else $error("result lost between stages");
`endif

endmodule
